// ===== design/tcp_pkg.sv =====
// ----------------------------------------------------------------------------
// tcp_pkg: shared types and constants for the text console with pointer
// Operation codes, payload structs, controller states and the command and
// status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcp_pkg;

  // Operation codes carried in the request op field
  localparam logic [2:0] OP_PUT_CHAR     = 3'd0;
  localparam logic [2:0] OP_PUT_HEX      = 3'd1;
  localparam logic [2:0] OP_PTR_ACTIVATE = 3'd2;
  localparam logic [2:0] OP_PTR_MOVE     = 3'd3;
  localparam logic [2:0] OP_READ_CELL    = 3'd4;

  // Character and attribute constants
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] ATTR_DEFAULT = 8'h07;

  // Request payload
  typedef struct packed {
    logic [2:0]        op;
    logic [7:0]        char_code;
    logic signed [7:0] delta_col;
    logic signed [7:0] delta_row;
    logic [10:0]       cell_index;
  } req_t;

  // Response payload
  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [6:0]  pointer_col;
    logic [4:0]  pointer_row;
    logic [15:0] cell_value;
    logic        screen_cleared;
  } rsp_t;

  // Which character the emit step prints
  typedef enum logic [1:0] {
    EMIT_RAW,
    EMIT_HEX_HI,
    EMIT_HEX_LO
  } emit_sel_t;

  // Controller states
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_EMIT,
    S_EMIT_HI,
    S_EMIT_LO,
    S_CLEAR,
    S_CLEAR_HI,
    S_CENTER,
    S_UNDO_RD,
    S_UNDO_WR,
    S_MOVE,
    S_SWAP_RD,
    S_SWAP_WR,
    S_READ,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic      accept;
    logic      emit;
    emit_sel_t emit_sel;
    logic      sweep_init;
    logic      sweep_clear;
    logic      mouse_center;
    logic      mouse_move;
    logic      attr_rd_mouse;
    logic      attr_swap_wr;
    logic      cell_rd;
    logic      out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       emit_clear;
    logic       sweep_last;
    logic       out_free;
  } status_t;

  // Uppercase ASCII hex digit for a nibble
  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    logic [7:0] base;
    base = (nib < 4'd10) ? 8'h30 : 8'h37;
    return base + {4'b0, nib};
  endfunction

endpackage

// ===== design/text_console_with_pointer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_with_pointer_core: text console with mouse pointer
// Owns a COLUMNS x ROWS screen of attribute/character cells, a text cursor
// and a pointer; one response per request.
// ----------------------------------------------------------------------------
//   channel   signals                    payload   direction
//   request   req_valid / req_ready      req_t     into the block
//   response  rsp_valid / rsp_ready      rsp_t     out of the block
//
// After reset every cell of the screen is filled before req_ready rises.
// Each request steps through its controller states from accept to response;
// a pointer activate or move reads the attribute under the pointer into a
// register and writes the swapped attribute in the following cycle.
// A put that scrolls past the last row adds a clear sweep of every cell.
// One request is in flight at a time; a result held in the response register
// does not block the next transfer in, only the next result.
// ----------------------------------------------------------------------------
module text_console_with_pointer_core import tcp_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t    cmd;
  status_t status;

  // Sequencer
  tcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Screen, positions and response register
  tcp_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== design/tcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcp_ctrl: operation sequencer
// Steps each request through emit, clear sweep, pointer swap or cell read
// and issues one command bundle per cycle to the datapath.
// ----------------------------------------------------------------------------
module tcp_ctrl import tcp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  output cmd_t    cmd,
  input  status_t status
);

  state_t state, state_next;

  // State register; reset starts the screen initialization sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit_sel = EMIT_RAW;
    req_ready  = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.sweep_init = 1'b1;
        if (status.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.op)
          OP_PUT_CHAR:     state_next = S_EMIT;
          OP_PUT_HEX:      state_next = S_EMIT_HI;
          OP_PTR_ACTIVATE: state_next = S_CENTER;
          OP_PTR_MOVE:     state_next = S_UNDO_RD;
          OP_READ_CELL:    state_next = S_READ;
          default:         state_next = S_DONE;
        endcase
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = status.emit_clear ? S_CLEAR : S_DONE;
      end
      S_EMIT_HI: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = EMIT_HEX_HI;
        state_next   = status.emit_clear ? S_CLEAR_HI : S_EMIT_LO;
      end
      S_EMIT_LO: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = EMIT_HEX_LO;
        state_next   = status.emit_clear ? S_CLEAR : S_DONE;
      end
      S_CLEAR: begin
        cmd.sweep_clear = 1'b1;
        if (status.sweep_last) state_next = S_DONE;
      end
      S_CLEAR_HI: begin
        cmd.sweep_clear = 1'b1;
        if (status.sweep_last) state_next = S_EMIT_LO;
      end
      S_CENTER: begin
        cmd.mouse_center = 1'b1;
        state_next       = S_SWAP_RD;
      end
      S_UNDO_RD: begin
        cmd.attr_rd_mouse = 1'b1;
        state_next        = S_UNDO_WR;
      end
      S_UNDO_WR: begin
        cmd.attr_swap_wr = 1'b1;
        state_next       = S_MOVE;
      end
      S_MOVE: begin
        cmd.mouse_move = 1'b1;
        state_next     = S_SWAP_RD;
      end
      S_SWAP_RD: begin
        cmd.attr_rd_mouse = 1'b1;
        state_next        = S_SWAP_WR;
      end
      S_SWAP_WR: begin
        cmd.attr_swap_wr = 1'b1;
        state_next       = S_DONE;
      end
      S_READ: begin
        cmd.cell_rd = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/tcp_datapath.sv =====
// ----------------------------------------------------------------------------
// tcp_datapath: screen memories, cursor, pointer and response register
// Attribute and character bytes live in two memories so that a character
// write or a clear sweep never needs a read of the attribute.
// ----------------------------------------------------------------------------
module tcp_datapath import tcp_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  input  logic    rsp_ready,
  output logic    rsp_valid,
  output rsp_t    rsp,
  input  cmd_t    cmd,
  output status_t status
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(CELLS);

  localparam logic [AW-1:0]   COLS_A     = AW'(COLUMNS);
  localparam logic [AW-1:0]   LAST_CELL  = AW'(CELLS - 1);
  localparam logic [CW:0]     COLS_W     = (CW+1)'(COLUMNS);
  localparam logic [RW:0]     ROWS_W     = (RW+1)'(ROWS);
  localparam logic [CW-1:0]   MID_COL    = CW'(COLUMNS / 2);
  localparam logic [RW-1:0]   MID_ROW    = RW'(ROWS / 2);
  localparam logic [CW-1:0]   MAX_COL    = CW'(COLUMNS - 1);
  localparam logic [RW-1:0]   MAX_ROW    = RW'(ROWS - 1);
  localparam logic signed [9:0] COLS_S   = 10'(COLUMNS);
  localparam logic signed [9:0] ROWS_S   = 10'(ROWS);

  // Screen storage
  logic [7:0] attr_mem [CELLS];
  logic [7:0] char_mem [CELLS];

  // Architectural and work registers
  logic [CW-1:0] text_col;
  logic [RW-1:0] text_row;
  logic [CW-1:0] mouse_col;
  logic [RW-1:0] mouse_row;
  logic [AW-1:0] sweep_cnt;
  logic          cleared;
  req_t          req_q;
  logic [7:0]    attr_q;
  logic [7:0]    char_q;

  // Addresses
  logic [AW-1:0] cursor_addr;
  logic [AW-1:0] mouse_addr;
  logic [AW-1:0] idx_addr;
  logic [31:0]   idx_wide;
  logic          idx_hit;

  assign cursor_addr = AW'(text_row) * COLS_A + AW'(text_col);
  assign mouse_addr  = AW'(mouse_row) * COLS_A + AW'(mouse_col);
  assign idx_wide    = 32'(req_q.cell_index);
  assign idx_addr    = idx_wide[AW-1:0];
  assign idx_hit     = idx_wide < 32'(CELLS);

  // Emit step: character select, cursor advance, wrap and clear detect
  logic [7:0]  emit_ch;
  logic        emit_active;
  logic        is_nl;
  logic        col_wrap;
  logic [CW:0] col_inc;
  logic [RW:0] row_inc;
  logic [CW-1:0] col_new;
  logic [RW:0]   row_new;
  logic          emit_clear;

  always_comb begin
    unique case (cmd.emit_sel)
      EMIT_HEX_HI: emit_ch = hex_ascii(req_q.char_code[7:4]);
      EMIT_HEX_LO: emit_ch = hex_ascii(req_q.char_code[3:0]);
      default:     emit_ch = req_q.char_code;
    endcase
    emit_active = cmd.emit && (emit_ch != CHAR_NUL);
    is_nl       = emit_ch == CHAR_NEWLINE;
    col_inc     = {1'b0, text_col} + 1'b1;
    row_inc     = {1'b0, text_row} + 1'b1;
    col_wrap    = !is_nl && (col_inc == COLS_W);
    col_new     = (is_nl || col_wrap) ? '0 : col_inc[CW-1:0];
    row_new     = (is_nl || col_wrap) ? row_inc : {1'b0, text_row};
    emit_clear  = emit_active && (row_new == ROWS_W);
  end

  // Pointer move with clamping in wide signed arithmetic
  logic signed [9:0] col_sum;
  logic signed [9:0] row_sum;
  logic [CW-1:0]     col_clamp;
  logic [RW-1:0]     row_clamp;

  always_comb begin
    col_sum = $signed(10'(mouse_col)) + {{2{req_q.delta_col[7]}}, req_q.delta_col};
    row_sum = $signed(10'(mouse_row)) + {{2{req_q.delta_row[7]}}, req_q.delta_row};
    priority if (col_sum < 0) begin
      col_clamp = '0;
    end else if (col_sum >= COLS_S) begin
      col_clamp = MAX_COL;
    end else begin
      col_clamp = col_sum[CW-1:0];
    end
    priority if (row_sum < 0) begin
      row_clamp = '0;
    end else if (row_sum >= ROWS_S) begin
      row_clamp = MAX_ROW;
    end else begin
      row_clamp = row_sum[RW-1:0];
    end
  end

  // Memory write port selection
  logic          char_we;
  logic [AW-1:0] char_waddr;
  logic [7:0]    char_wdata;
  logic          attr_we;
  logic [AW-1:0] attr_waddr;
  logic [7:0]    attr_wdata;
  logic          attr_re;
  logic [AW-1:0] attr_raddr;

  always_comb begin
    char_we    = cmd.sweep_init || cmd.sweep_clear || (emit_active && !is_nl);
    char_waddr = (cmd.sweep_init || cmd.sweep_clear) ? sweep_cnt : cursor_addr;
    char_wdata = (cmd.sweep_init || cmd.sweep_clear) ? CHAR_SPACE : emit_ch;
    attr_we    = cmd.sweep_init || cmd.attr_swap_wr;
    attr_waddr = cmd.sweep_init ? sweep_cnt : mouse_addr;
    attr_wdata = cmd.sweep_init ? ATTR_DEFAULT : {attr_q[3:0], attr_q[7:4]};
    attr_re    = cmd.attr_rd_mouse || cmd.cell_rd;
    attr_raddr = cmd.cell_rd ? idx_addr : mouse_addr;
  end

  // Character memory
  always_ff @(posedge clk) begin
    if (char_we) begin
      char_mem[char_waddr] <= char_wdata;
    end
    if (cmd.cell_rd) begin
      char_q <= char_mem[idx_addr];
    end
  end

  // Attribute memory
  always_ff @(posedge clk) begin
    if (attr_we) begin
      attr_mem[attr_waddr] <= attr_wdata;
    end
    if (attr_re) begin
      attr_q <= attr_mem[attr_raddr];
    end
  end

  // Sweep counter shared by the reset fill and the screen clear
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep_init || cmd.sweep_clear) begin
      sweep_cnt <= (sweep_cnt == LAST_CELL) ? '0 : sweep_cnt + 1'b1;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= req;
    end
  end

  // Cursor and pointer positions
  always_ff @(posedge clk) begin
    if (rst) begin
      text_col  <= '0;
      text_row  <= '0;
      mouse_col <= MID_COL;
      mouse_row <= MID_ROW;
      cleared   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        cleared <= 1'b0;
      end else if (emit_clear) begin
        cleared <= 1'b1;
      end
      if (emit_active) begin
        if (emit_clear) begin
          text_col <= '0;
          text_row <= '0;
        end else begin
          text_col <= col_new;
          text_row <= row_new[RW-1:0];
        end
      end
      if (cmd.mouse_center) begin
        mouse_col <= MID_COL;
        mouse_row <= MID_ROW;
      end else if (cmd.mouse_move) begin
        mouse_col <= col_clamp;
        mouse_row <= row_clamp;
      end
    end
  end

  // Response register; a finished result waits here for the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.cursor_col     <= 7'(text_col);
      rsp.cursor_row     <= 5'(text_row);
      rsp.pointer_col    <= 7'(mouse_col);
      rsp.pointer_row    <= 5'(mouse_row);
      rsp.cell_value     <= (req_q.op == OP_READ_CELL && idx_hit) ? {attr_q, char_q} : '0;
      rsp.screen_cleared <= cleared;
    end
  end

  // Status back to the controller
  assign status.op         = req_q.op;
  assign status.emit_clear = emit_clear;
  assign status.sweep_last = sweep_cnt == LAST_CELL;
  assign status.out_free   = !rsp_valid || rsp_ready;

  // Cursor stays on the screen
  assert property (@(posedge clk) disable iff (rst)
    (32'(text_col) < 32'(COLUMNS)) && (32'(text_row) < 32'(ROWS)))
    else $error("text cursor off screen");

  // Pointer stays on the screen
  assert property (@(posedge clk) disable iff (rst)
    (32'(mouse_col) < 32'(COLUMNS)) && (32'(mouse_row) < 32'(ROWS)))
    else $error("pointer off screen");

  // A clear sweep only runs after the cursor went home
  assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_clear |-> (text_col == '0) && (text_row == '0))
    else $error("clear sweep with cursor away from home");

  // Only a cell read reports cell contents
  assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && req_q.op != OP_READ_CELL) |=> rsp.cell_value == '0)
    else $error("cell value on a non-read operation");

endmodule
